>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, with checks off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence at the next edge of clk.
`define ASSERT_NEXT(label, cond, cons, msg) \
    `ASSERT_CLK(label, (cond) |=> (cons), msg)

`endif

>>> src/kpsc_pkg.sv
// ----------------------------------------------------------------------------
// kpsc_pkg
// Shared types and constants of the keypad scanner with auto-repeat.
// ----------------------------------------------------------------------------
package kpsc_pkg;

    localparam int KEYS_W       = 6;
    localparam int NUM_KEYS_DEF = 6;
    localparam int KEY_W        = 3;
    localparam int TICK_W       = 10;
    localparam int PER_W        = 8;
    localparam int REP_W        = 4;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    typedef logic [KEYS_W-1:0] keys_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [PER_W-1:0]  per_t;
    typedef logic [REP_W-1:0]  rep_t;

    localparam tick_t TICK_MAX = '1;

    localparam key_t ARROW_KEY_LO = 3'd2;
    localparam key_t ARROW_KEY_HI = 3'd3;

    localparam per_t PERIOD_NORMAL_RST = 8'd16;
    localparam per_t PERIOD_ARROWS_RST = 8'd12;
    localparam rep_t ACCEL_AFTER_RST   = 4'd10;

    typedef enum logic [1:0] {
        PH_CHECK   = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_RELEASE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } ev_t;

    typedef enum logic [1:0] {
        REG_PERIOD_NORMAL = 2'd0,
        REG_PERIOD_ARROWS = 2'd1,
        REG_ACCEL_AFTER   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        per_t period_normal;
        per_t period_arrows;
        rep_t accel_after;
    } cfg_t;

endpackage

>>> src/kpsc_if.sv
// ----------------------------------------------------------------------------
// kpsc_key_if / kpsc_evt_if
// Valid/ready channels for scan ticks and key events.
// ----------------------------------------------------------------------------
interface kpsc_key_if;
    logic                valid;
    logic                ready;
    kpsc_pkg::keys_t     keys_pressed;

    modport source (output valid, output keys_pressed, input ready);
    modport sink   (input valid, input keys_pressed, output ready);
endinterface

interface kpsc_evt_if;
    logic                valid;
    logic                ready;
    logic [1:0]          event_res;
    kpsc_pkg::key_t      key_id;

    modport source (output valid, output event_res, output key_id, input ready);
    modport sink   (input valid, input event_res, input key_id, output ready);
endinterface

>>> src/kpsc_regs.sv
// ----------------------------------------------------------------------------
// kpsc_regs
// APB-style configuration registers: repeat periods and acceleration count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kpsc_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kpsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [kpsc_pkg::DATA_W-1:0]   pwdata,
    output logic [kpsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output kpsc_pkg::cfg_t                cfg
);

    kpsc_pkg::cfg_t     cfg_reg;
    logic               wr_en;
    kpsc_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = kpsc_pkg::reg_idx_t'(paddr[kpsc_pkg::ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_normal <= kpsc_pkg::PERIOD_NORMAL_RST;
            cfg_reg.period_arrows <= kpsc_pkg::PERIOD_ARROWS_RST;
            cfg_reg.accel_after   <= kpsc_pkg::ACCEL_AFTER_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                kpsc_pkg::REG_PERIOD_NORMAL:
                    cfg_reg.period_normal <= pwdata[kpsc_pkg::PER_W-1:0];
                kpsc_pkg::REG_PERIOD_ARROWS:
                    cfg_reg.period_arrows <= pwdata[kpsc_pkg::PER_W-1:0];
                kpsc_pkg::REG_ACCEL_AFTER:
                    cfg_reg.accel_after   <= pwdata[kpsc_pkg::REP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            kpsc_pkg::REG_PERIOD_NORMAL:
                prdata = kpsc_pkg::DATA_W'(cfg_reg.period_normal);
            kpsc_pkg::REG_PERIOD_ARROWS:
                prdata = kpsc_pkg::DATA_W'(cfg_reg.period_arrows);
            kpsc_pkg::REG_ACCEL_AFTER:
                prdata = kpsc_pkg::DATA_W'(cfg_reg.accel_after);
            default:
                prdata = '0;
        endcase
    end

    `ASSERT_NEXT(a_accel_written, wr_en && idx == kpsc_pkg::REG_ACCEL_AFTER, cfg_reg.accel_after == $past(pwdata[kpsc_pkg::REP_W-1:0]), "accel_after write lost")

endmodule

>>> src/kpsc_core.sv
// ----------------------------------------------------------------------------
// kpsc_core
// Debounce state machine with short press, long press and accelerating auto-repeat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kpsc_core
#(
    parameter int NUM_KEYS = kpsc_pkg::NUM_KEYS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  kpsc_pkg::keys_t   keys_pressed,
    input  kpsc_pkg::cfg_t    cfg,
    output kpsc_pkg::ev_t     ev,
    output kpsc_pkg::key_t    key_id
);

    localparam int SCAN = (NUM_KEYS < kpsc_pkg::KEYS_W) ? NUM_KEYS : kpsc_pkg::KEYS_W;

    kpsc_pkg::phase_t phase_reg, phase_next;
    kpsc_pkg::tick_t  tick_reg, tick_next;
    kpsc_pkg::rep_t   rep_reg, rep_next;
    logic             held_reg, held_next;
    kpsc_pkg::key_t   key_reg, key_next;

    logic             pressed;
    kpsc_pkg::key_t   first_key;
    kpsc_pkg::per_t   per;

    // lowest-numbered pressed key wins
    always_comb
    begin
        first_key = '0;
        pressed   = 1'b0;
        for (int n = SCAN - 1; n >= 0; n--)
        begin
            if (keys_pressed[n])
            begin
                first_key = kpsc_pkg::key_t'(n);
                pressed   = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        rep_next   = rep_reg;
        held_next  = held_reg;
        key_next   = key_reg;
        ev         = kpsc_pkg::EV_NONE;
        per        = cfg.period_normal;
        unique case (phase_reg)
            kpsc_pkg::PH_CONFIRM:
            begin
                if (pressed)
                begin
                    key_next  = first_key;
                    held_next = 1'b1;
                    if (tick_reg != kpsc_pkg::TICK_MAX)
                        tick_next = tick_reg + 1'b1;
                    if (key_next == kpsc_pkg::ARROW_KEY_LO ||
                        key_next == kpsc_pkg::ARROW_KEY_HI)
                        per = cfg.period_arrows;
                    // first long event after twice the period
                    if (rep_reg == '0 &&
                        tick_next > kpsc_pkg::TICK_W'({per, 1'b0}))
                    begin
                        ev        = kpsc_pkg::EV_LONG;
                        tick_next = '0;
                        held_next = 1'b0;
                        rep_next  = rep_reg + 1'b1;
                    end
                    if (rep_next < cfg.accel_after && rep_next != '0)
                    begin
                        if (tick_next > kpsc_pkg::TICK_W'(per))
                        begin
                            ev        = kpsc_pkg::EV_LONG;
                            tick_next = '0;
                            held_next = 1'b0;
                            rep_next  = rep_next + 1'b1;
                        end
                    end
                    else if (rep_next >= cfg.accel_after)
                    begin
                        // fast repeat at a quarter period
                        if (tick_next > kpsc_pkg::TICK_W'(per >> 2))
                        begin
                            ev        = kpsc_pkg::EV_LONG;
                            tick_next = '0;
                            held_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    rep_next = '0;
                    if (held_reg)
                    begin
                        ev         = kpsc_pkg::EV_SHORT;
                        phase_next = kpsc_pkg::PH_RELEASE;
                    end
                    else
                        phase_next = kpsc_pkg::PH_CHECK;
                end
            end
            kpsc_pkg::PH_RELEASE:
            begin
                if (!pressed)
                    phase_next = kpsc_pkg::PH_CHECK;
            end
            default:
            begin
                phase_next = pressed ? kpsc_pkg::PH_CONFIRM : kpsc_pkg::PH_CHECK;
                tick_next  = '0;
                held_next  = 1'b0;
            end
        endcase
    end

    assign key_id = (ev != kpsc_pkg::EV_NONE) ? key_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kpsc_pkg::PH_CHECK;
            tick_reg  <= '0;
            rep_reg   <= '0;
            held_reg  <= 1'b0;
            key_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            rep_reg   <= rep_next;
            held_reg  <= held_next;
            key_reg   <= key_next;
        end
    end

    `ASSERT_CLK(a_long_in_confirm, step && ev == kpsc_pkg::EV_LONG |-> phase_reg == kpsc_pkg::PH_CONFIRM && pressed, "long event outside held confirm")
    `ASSERT_NEXT(a_short_to_release, step && ev == kpsc_pkg::EV_SHORT, phase_reg == kpsc_pkg::PH_RELEASE, "short event did not enter release")
    `ASSERT_NEXT(a_check_clears, step && phase_reg == kpsc_pkg::PH_CHECK, tick_reg == '0 && !held_reg, "check phase left stale counters")
    `ASSERT_NEXT(a_long_clears_mark, step && ev == kpsc_pkg::EV_LONG, tick_reg == '0 && !held_reg, "long event left counters")

endmodule

>>> src/keypad_scan_with_autorepeat_unit.sv
// ----------------------------------------------------------------------------
// keypad_scan_with_autorepeat_unit
// Keypad debounce with short press, long press and accelerating auto-repeat.
// ----------------------------------------------------------------------------
//  channel   dir  payload                    handshake
//  key_in    in   keys_pressed[5:0]          valid/ready
//  evt_out   out  event_res[1:0], key_id[2:0] valid/ready
//  apb       in   paddr[3:0], pwdata[31:0]   psel/penable, pready tied high
//
//  One request per cycle unless stalled; each scan tick yields one event.
//  The input register and the event register form a two-stage pipeline.
//  A stalled event register holds the tick in the input register; the
//  input side keeps taking requests while the input register is free.
//  rst_n clears phase, counters and valid flags; registers return to
//  16, 12 and 10.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_scan_with_autorepeat_unit
#(
    parameter int NUM_KEYS = kpsc_pkg::NUM_KEYS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    kpsc_key_if.sink                      key_in,
    kpsc_evt_if.source                    evt_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kpsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [kpsc_pkg::DATA_W-1:0]   pwdata,
    output logic [kpsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    kpsc_pkg::cfg_t   cfg;
    logic             in_valid_reg, in_valid_next;
    kpsc_pkg::keys_t  in_keys_reg;
    logic             out_valid_reg, out_valid_next;
    kpsc_pkg::ev_t    out_ev_reg;
    kpsc_pkg::key_t   out_key_reg;
    logic             advance;
    logic             take;
    logic             step;
    kpsc_pkg::ev_t    ev;
    kpsc_pkg::key_t   key_id;

    kpsc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kpsc_core #(.NUM_KEYS(NUM_KEYS)) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .keys_pressed (in_keys_reg),
        .cfg          (cfg),
        .ev           (ev),
        .key_id       (key_id)
    );

    assign advance      = !out_valid_reg || evt_out.ready;
    assign step         = in_valid_reg && advance;
    assign key_in.ready = !in_valid_reg || advance;
    assign take         = key_in.valid && key_in.ready;

    assign in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_keys_reg <= key_in.keys_pressed;
        if (step)
        begin
            out_ev_reg  <= ev;
            out_key_reg <= key_id;
        end
    end

    assign evt_out.valid     = out_valid_reg;
    assign evt_out.event_res = out_ev_reg;
    assign evt_out.key_id    = out_key_reg;

    `ASSERT_NEXT(a_stall_holds_tick, in_valid_reg && !advance, in_valid_reg && $stable(in_keys_reg), "pending tick lost during stall")
    `ASSERT_NEXT(a_step_fills_out, step, out_valid_reg, "processed tick did not reach event register")

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad scanner: streams scan ticks under random
// source bursts and sink stalls, predicts every key event in a scoreboard and
// sweeps the repeat period and acceleration registers over the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class keypad_event_scoreboard;

    typedef struct packed {
        kpsc_pkg::ev_t  ev;
        kpsc_pkg::key_t key;
    } key_event_t;

    kpsc_pkg::per_t   period_normal;
    kpsc_pkg::per_t   period_arrows;
    kpsc_pkg::rep_t   accel_after;
    kpsc_pkg::phase_t phase;
    int               ticks_held;
    kpsc_pkg::rep_t   repeats;
    bit               held_mark;
    kpsc_pkg::key_t   latched;
    key_event_t       events_due[$];
    int               errors;

    function new();
        period_normal = kpsc_pkg::PERIOD_NORMAL_RST;
        period_arrows = kpsc_pkg::PERIOD_ARROWS_RST;
        accel_after   = kpsc_pkg::ACCEL_AFTER_RST;
        phase         = kpsc_pkg::PH_CHECK;
        ticks_held    = 0;
        repeats       = '0;
        held_mark     = 1'b0;
        latched       = '0;
        errors        = 0;
    endfunction

    function void write_reg(kpsc_pkg::reg_idx_t idx, logic [kpsc_pkg::DATA_W-1:0] value);
        case (idx)
            kpsc_pkg::REG_PERIOD_NORMAL: period_normal = value[kpsc_pkg::PER_W-1:0];
            kpsc_pkg::REG_PERIOD_ARROWS: period_arrows = value[kpsc_pkg::PER_W-1:0];
            kpsc_pkg::REG_ACCEL_AFTER:   accel_after   = value[kpsc_pkg::REP_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return events_due.size();
    endfunction

    function void note_scan(kpsc_pkg::keys_t keys);
        key_event_t    due;
        int            per;
        bit            pressed;
        kpsc_pkg::ev_t ev;
        ev      = kpsc_pkg::EV_NONE;
        pressed = (keys != '0);
        case (phase)
            kpsc_pkg::PH_CONFIRM:
            begin
                if (pressed)
                begin
                    for (int n = kpsc_pkg::NUM_KEYS_DEF - 1; n >= 0; n--)
                    begin
                        if (keys[n])
                            latched = kpsc_pkg::key_t'(n);
                    end
                    held_mark = 1'b1;
                    if (ticks_held < kpsc_pkg::TICK_MAX)
                        ticks_held++;
                    per = (latched == kpsc_pkg::ARROW_KEY_LO ||
                           latched == kpsc_pkg::ARROW_KEY_HI) ?
                          int'(period_arrows) : int'(period_normal);
                    if (repeats == 0 && ticks_held > 2 * per)
                    begin
                        ev         = kpsc_pkg::EV_LONG;
                        ticks_held = 0;
                        held_mark  = 1'b0;
                        repeats++;
                    end
                    if (repeats < accel_after && repeats != 0)
                    begin
                        if (ticks_held > per)
                        begin
                            ev         = kpsc_pkg::EV_LONG;
                            ticks_held = 0;
                            held_mark  = 1'b0;
                            repeats++;
                        end
                    end
                    else if (repeats >= accel_after)
                    begin
                        if (ticks_held > per / 4)
                        begin
                            ev         = kpsc_pkg::EV_LONG;
                            ticks_held = 0;
                            held_mark  = 1'b0;
                        end
                    end
                end
                else
                begin
                    repeats = '0;
                    if (held_mark)
                    begin
                        ev    = kpsc_pkg::EV_SHORT;
                        phase = kpsc_pkg::PH_RELEASE;
                    end
                    else
                        phase = kpsc_pkg::PH_CHECK;
                end
            end
            kpsc_pkg::PH_RELEASE:
            begin
                if (!pressed)
                    phase = kpsc_pkg::PH_CHECK;
            end
            default:
            begin
                phase      = pressed ? kpsc_pkg::PH_CONFIRM : kpsc_pkg::PH_CHECK;
                ticks_held = 0;
                held_mark  = 1'b0;
            end
        endcase
        due.ev  = ev;
        due.key = (ev != kpsc_pkg::EV_NONE) ? latched : '0;
        events_due.push_back(due);
    endfunction

    task report(string msg);
        $display("%0t ERROR %s", $realtime, msg);
        errors++;
    endtask

    task check_event(logic [1:0] ev, kpsc_pkg::key_t key);
        key_event_t due;
        if (events_due.size() == 0)
        begin
            report($sformatf("event %0d key %0d with none due", ev, key));
            return;
        end
        due = events_due.pop_front();
        if (ev !== due.ev)
            report($sformatf("event_res %0d, predicted %0d", ev, due.ev));
        if (key !== due.key)
            report($sformatf("key_id %0d, predicted %0d", key, due.key));
    endtask

endclass

module testbench;

    localparam int SCANS_PER_PHASE = 100;
    localparam int NUM_CFGS        = 10;
    localparam int NUM_DIRECTED    = 25;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [kpsc_pkg::ADDR_W-1:0] paddr;
    logic [kpsc_pkg::DATA_W-1:0] pwdata;
    logic [kpsc_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    kpsc_key_if scan_ch();
    kpsc_evt_if event_ch();

    keypad_event_scoreboard board = new();

    int burst_left;
    int scans_sent;

    kpsc_pkg::cfg_t phase_cfgs [NUM_CFGS] = '{
        '{8'd1,   8'd1,   4'd1},
        '{8'd0,   8'd0,   4'd0},
        '{8'd255, 8'd255, 4'd15},
        '{8'd2,   8'd3,   4'd0},
        '{8'd4,   8'd7,   4'd3},
        '{8'd0,   8'd5,   4'd15},
        '{8'd1,   8'd255, 4'd1},
        '{8'd8,   8'd6,   4'd4},
        '{8'd3,   8'd0,   4'd2},
        '{8'd16,  8'd12,  4'd10}
    };

    kpsc_pkg::keys_t directed_scans [NUM_DIRECTED] = '{
        6'h00, 6'h3F, 6'h3F, 6'h00, 6'h00,
        6'h20, 6'h20, 6'h00, 6'h00,
        6'h04, 6'h0C, 6'h00, 6'h00,
        6'h08, 6'h08, 6'h00,
        6'h02, 6'h00,
        6'h10, 6'h10, 6'h00, 6'h10, 6'h00,
        6'h01, 6'h00
    };

    keypad_scan_with_autorepeat_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (scan_ch),
        .evt_out (event_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #6_000_000;
        $display("keypad_scan_with_autorepeat_unit: mismatch");
        $finish;
    end

    initial
    begin
        int mode;
        int mode_left;
        int run_left;
        bit run_ready;
        mode           = 0;
        mode_left      = 0;
        run_left       = 0;
        run_ready      = 1'b0;
        event_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (mode)
                0: event_ch.ready = 1'b1;
                1: event_ch.ready = ~event_ch.ready;
                2: event_ch.ready = ($urandom_range(0, 2) != 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_ready = ~run_ready;
                        run_left  = run_ready ? $urandom_range(1, 6) : $urandom_range(1, 12);
                    end
                    run_left--;
                    event_ch.ready = run_ready;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && event_ch.valid && event_ch.ready)
            board.check_event(event_ch.event_res, event_ch.key_id);
    end

    task automatic send_scan(kpsc_pkg::keys_t keys);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 6);
        end
        burst_left--;
        repeat (gap)
        begin
            @(negedge clk);
            scan_ch.valid = 1'b0;
        end
        @(negedge clk);
        scan_ch.valid        = 1'b1;
        scan_ch.keys_pressed = keys;
        do
            @(posedge clk);
        while (!scan_ch.ready);
        board.note_scan(keys);
        scans_sent++;
    endtask

    // hold off until every predicted event has come out
    task automatic drain();
        @(negedge clk);
        scan_ch.valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(kpsc_pkg::reg_idx_t idx, logic [kpsc_pkg::PER_W-1:0] value);
        logic [kpsc_pkg::DATA_W-1:0] noise;
        logic [kpsc_pkg::DATA_W-1:0] expected;
        noise    = $urandom;
        expected = (idx == kpsc_pkg::REG_ACCEL_AFTER) ?
                   kpsc_pkg::DATA_W'(value[kpsc_pkg::REP_W-1:0]) :
                   kpsc_pkg::DATA_W'(value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {noise[kpsc_pkg::DATA_W-1:kpsc_pkg::PER_W], value};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.write_reg(idx, pwdata);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== expected)
            board.report($sformatf("register %0d reads %0h, written %0h",
                                   idx, prdata, expected));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic kpsc_pkg::keys_t random_press();
        int              low;
        kpsc_pkg::keys_t upper;
        low   = $urandom_range(0, kpsc_pkg::KEYS_W - 1);
        upper = kpsc_pkg::keys_t'($urandom);
        return kpsc_pkg::keys_t'(1 << low) | (upper & ~kpsc_pkg::keys_t'((2 << low) - 1));
    endfunction

    task automatic press_sequence(int hold_len);
        kpsc_pkg::keys_t held;
        held = random_press();
        repeat (hold_len)
        begin
            if ($urandom_range(0, 3) == 0)
                held = random_press();
            send_scan(held);
        end
        repeat ($urandom_range(1, 4)) send_scan('0);
    endtask

    task automatic run_phase(bit pause_midway);
        int start;
        int pmax;
        int cap;
        int sel;
        bit paused;
        start  = scans_sent;
        paused = 1'b0;
        pmax   = (board.period_normal > board.period_arrows) ?
                 int'(board.period_normal) : int'(board.period_arrows);
        cap    = 2 * pmax + (int'(board.accel_after) + 2) * (pmax + 1);
        if (cap > 600)
            cap = 600;
        while (scans_sent - start < SCANS_PER_PHASE)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 3)
                repeat ($urandom_range(1, 6))
                    send_scan(kpsc_pkg::keys_t'($urandom_range(0, 63)));
            else if (sel < 10)
                press_sequence($urandom_range(1, 3));
            else if (sel < 17)
                press_sequence($urandom_range(1, (cap < 80) ? cap : 80));
            else
                press_sequence($urandom_range(1, cap));
            if (pause_midway && !paused && scans_sent - start > SCANS_PER_PHASE / 2)
            begin
                paused = 1'b1;
                drain();
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        scan_ch.valid        = 1'b0;
        scan_ch.keys_pressed = '0;
        burst_left           = 0;
        scans_sent           = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_scans[i])
            send_scan(directed_scans[i]);
        run_phase(1'b1);

        foreach (phase_cfgs[i])
        begin
            drain();
            write_reg(kpsc_pkg::REG_PERIOD_NORMAL, phase_cfgs[i].period_normal);
            write_reg(kpsc_pkg::REG_PERIOD_ARROWS, phase_cfgs[i].period_arrows);
            write_reg(kpsc_pkg::REG_ACCEL_AFTER,
                      kpsc_pkg::PER_W'(phase_cfgs[i].accel_after));
            run_phase(1'b0);
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("keypad_scan_with_autorepeat_unit: match");
        else
            $display("keypad_scan_with_autorepeat_unit: mismatch");
        $finish;
    end

endmodule
